// ----- rtl/core/bsdq_pkg.sv -----
// Shared types, codes and defaults for the bounded sorted deque core.
package bsdq_pkg;

  // Default list capacity handed to the top level.
  localparam int DEF_CAPACITY = 16;

  // Field widths of the command and result transactions.
  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // One result transaction as it travels to the output register.
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic [COUNT_W-1:0]       entry_count;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] tail_value;
  } result_t;

endpackage

// ----- rtl/core/bounded_sorted_deque_core.sv -----
// Top level of the bounded sorted deque: command sequencer over one list RAM.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  command | in_valid, in_stall, cmd, value            | in
//  result  | out_valid, out_stall, status, found,      | out
//          | entry_count, head_value, tail_value       |
//
// One command at a time runs a sequencer over the RAM and one compare unit;
// each entry scanned or moved takes a read state, then a compare or write state.
// Every command ends in the head/tail read-back states S_RD_HEAD, S_RD_TAIL
// and S_FIN; the sequencer then returns to idle before the next command.
// Reset clears the count and the sequencer; RAM contents need no clearing.
// in_stall stays high from acceptance until the result enters the output
// register, which holds it while out_stall is high.
module bounded_sorted_deque_core #(
  parameter int CAPACITY = bsdq_pkg::DEF_CAPACITY
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [bsdq_pkg::CMD_W-1:0]             cmd,
  input  logic signed [bsdq_pkg::DATA_W-1:0]     value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [bsdq_pkg::STATUS_W-1:0]          status,
  output logic                                   found,
  output logic [bsdq_pkg::COUNT_W-1:0]           entry_count,
  output logic signed [bsdq_pkg::DATA_W-1:0]     head_value,
  output logic signed [bsdq_pkg::DATA_W-1:0]     tail_value
);
  import bsdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CK, S_UP_RD, S_UP_WR,
    S_DN_RD, S_DN_WR, S_RD_HEAD, S_RD_TAIL, S_FIN
  } state_t;

  state_t                   state;
  logic [CMD_W-1:0]         cmd_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            pos;
  logic [STATUS_W-1:0]      status_r;
  logic                     found_r;
  logic signed [DATA_W-1:0] head_r;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [DATA_W-1:0]        wdata;
  logic [AW-1:0]            raddr;
  logic [DATA_W-1:0]        rdata;
  logic                     out_ready;
  logic                     load;
  result_t                  result;
  logic                     accept;
  logic                     hit;
  logic [CW-1:0]            idx_p1;
  logic [CW-1:0]            idx_m1;
  logic [CW-1:0]            last;
  logic [CW+COUNT_W-1:0]    cnt_ext;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_p1   = idx + CW'(1);
  assign idx_m1   = idx - CW'(1);
  assign last     = (cnt == '0) ? '0 : cnt - CW'(1);

  // Shared compare unit: greater-than for sorted insert, equality otherwise.
  assign hit = (cmd_r == CMD_INSERT) ? ($signed(rdata) > val_r)
                                     : (rdata == val_r);

  // RAM port steering by sequencer state.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = val_r;
    raddr = '0;
    case (state)
      S_SCAN_RD: begin
        if (idx != cnt) raddr = idx[AW-1:0];
      end
      S_UP_RD: begin
        if (idx == pos) begin
          we    = 1'b1;
          waddr = pos[AW-1:0];
        end else begin
          raddr = idx_m1[AW-1:0];
        end
      end
      S_UP_WR: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        wdata = rdata;
      end
      S_DN_RD: begin
        if (idx_p1 < cnt) raddr = idx_p1[AW-1:0];
      end
      S_DN_WR: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        wdata = rdata;
      end
      S_RD_TAIL, S_FIN: raddr = last[AW-1:0];
      default: ;
    endcase
  end

  // Result assembled from the sequencer registers and the tail read.
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt};
  always_comb begin
    result.status      = status_r;
    result.found       = found_r;
    result.entry_count = cnt_ext[COUNT_W-1:0];
    result.head_value  = (cnt == '0) ? '0 : head_r;
    result.tail_value  = (cnt == '0) ? '0 : $signed(rdata);
  end
  assign load = (state == S_FIN) && out_ready;

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r    <= cmd;
            val_r    <= value;
            status_r <= ST_DONE;
            found_r  <= 1'b0;
            idx      <= '0;
            unique case (cmd)
              CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                if (cnt == CAP) begin
                  status_r <= ST_FULL;
                  state    <= S_RD_HEAD;
                end else if (cmd == CMD_PUSH_FRONT) begin
                  pos   <= '0;
                  idx   <= cnt;
                  state <= S_UP_RD;
                end else if (cmd == CMD_PUSH_BACK) begin
                  pos   <= cnt;
                  idx   <= cnt;
                  state <= S_UP_RD;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              CMD_POP_FRONT, CMD_POP_BACK: begin
                if (cnt == '0) begin
                  status_r <= ST_EMPTY;
                  state    <= S_RD_HEAD;
                end else if (cmd == CMD_POP_FRONT) begin
                  state <= S_DN_RD;
                end else begin
                  cnt   <= cnt - CW'(1);
                  state <= S_RD_HEAD;
                end
              end
              CMD_DELETE, CMD_SEARCH: state <= S_SCAN_RD;
              default: state <= S_RD_HEAD;
            endcase
          end
        end
        // Walk from the front until the compare unit hits or the list ends.
        S_SCAN_RD: begin
          if (idx == cnt) begin
            if (cmd_r == CMD_INSERT) begin
              pos   <= cnt;
              state <= S_UP_RD;
            end else begin
              status_r <= ST_NOTFOUND;
              state    <= S_RD_HEAD;
            end
          end else begin
            state <= S_SCAN_CK;
          end
        end
        S_SCAN_CK: begin
          if (hit) begin
            if (cmd_r == CMD_INSERT) begin
              pos   <= idx;
              idx   <= cnt;
              state <= S_UP_RD;
            end else begin
              found_r <= 1'b1;
              state   <= (cmd_r == CMD_DELETE) ? S_DN_RD : S_RD_HEAD;
            end
          end else begin
            idx   <= idx_p1;
            state <= S_SCAN_RD;
          end
        end
        // Move entries up one place from the back down to the gap, then fill it.
        S_UP_RD: begin
          if (idx == pos) begin
            cnt   <= cnt + CW'(1);
            state <= S_RD_HEAD;
          end else begin
            state <= S_UP_WR;
          end
        end
        S_UP_WR: begin
          idx   <= idx_m1;
          state <= S_UP_RD;
        end
        // Move entries down one place to close the gap at idx.
        S_DN_RD: begin
          if (idx_p1 >= cnt) begin
            cnt   <= cnt - CW'(1);
            state <= S_RD_HEAD;
          end else begin
            state <= S_DN_WR;
          end
        end
        S_DN_WR: begin
          idx   <= idx_p1;
          state <= S_DN_RD;
        end
        // Read back head, then tail, for the result.
        S_RD_HEAD: state <= S_RD_TAIL;
        S_RD_TAIL: begin
          head_r <= $signed(rdata);
          state  <= S_FIN;
        end
        S_FIN: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bsdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bsdq_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .result      (result),
    .ready       (out_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found       (found),
    .entry_count (entry_count),
    .head_value  (head_value),
    .tail_value  (tail_value)
  );

endmodule

// ----- rtl/core/bsdq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module bsdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read first: the read data is registered and shows the old word on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bsdq_out.sv -----
// Output register that holds one result transaction until the consumer takes it.
module bsdq_out (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  bsdq_pkg::result_t                      result,
  output logic                                   ready,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [bsdq_pkg::STATUS_W-1:0]          status,
  output logic                                   found,
  output logic [bsdq_pkg::COUNT_W-1:0]           entry_count,
  output logic signed [bsdq_pkg::DATA_W-1:0]     head_value,
  output logic signed [bsdq_pkg::DATA_W-1:0]     tail_value
);
  import bsdq_pkg::*;

  result_t held;

  // The register can take a new result when empty or being drained.
  assign ready = !out_valid || !out_stall;

  // Valid flag under reset; payload loads without reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign status      = held.status;
  assign found       = held.found;
  assign entry_count = held.entry_count;
  assign head_value  = held.head_value;
  assign tail_value  = held.tail_value;

endmodule

// ----- tb/sv/bsdq_result_checker.sv -----
// Result checker for the bounded sorted deque: shadow list, expected results, field compare.
`timescale 1ns / 100ps

module bsdq_result_checker #(
  parameter int CAPACITY = bsdq_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [bsdq_pkg::CMD_W-1:0]         cmd,
  input  logic signed [bsdq_pkg::DATA_W-1:0] value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [bsdq_pkg::STATUS_W-1:0]      status,
  input  logic                               found,
  input  logic [bsdq_pkg::COUNT_W-1:0]       entry_count,
  input  logic signed [bsdq_pkg::DATA_W-1:0] head_value,
  input  logic signed [bsdq_pkg::DATA_W-1:0] tail_value,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 checked,
  output int                                 full_rejects,
  output int                                 misses
);
  import bsdq_pkg::*;

  // Shadow copy of the list contents, front at index 0.
  logic signed [DATA_W-1:0] shadow_list[$];
  // Results still owed by the block, oldest first.
  result_t                  due_results[$];

  int errors;
  int n_checked;
  int n_full;
  int n_miss;

  // Apply one command to the shadow list and return the result it should produce.
  function automatic result_t apply_command(input logic [CMD_W-1:0] op,
                                            input logic signed [DATA_W-1:0] val);
    result_t r;
    int      pos;
    r.status = ST_DONE;
    r.found  = 1'b0;
    pos      = 0;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        if (shadow_list.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (op == CMD_PUSH_FRONT) begin
          shadow_list.push_front(val);
        end else if (op == CMD_PUSH_BACK) begin
          shadow_list.push_back(val);
        end else begin
          // Equal values stay ahead of the new one; it goes before the first larger value.
          while (pos < shadow_list.size() && shadow_list[pos] <= val) pos++;
          shadow_list.insert(pos, val);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (shadow_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (op == CMD_POP_FRONT) begin
          void'(shadow_list.pop_front());
        end else begin
          void'(shadow_list.pop_back());
        end
      end
      CMD_DELETE, CMD_SEARCH: begin
        // First match counted from the front.
        while (pos < shadow_list.size() && shadow_list[pos] != val) pos++;
        if (pos == shadow_list.size()) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found = 1'b1;
          if (op == CMD_DELETE) shadow_list.delete(pos);
        end
      end
      default: begin
        // The spare command code leaves the list alone.
      end
    endcase
    r.entry_count = COUNT_W'(shadow_list.size());
    r.head_value  = (shadow_list.size() != 0) ? shadow_list[0] : '0;
    r.tail_value  = (shadow_list.size() != 0) ? shadow_list[$] : '0;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic signed [DATA_W:0] want,
                               input logic signed [DATA_W:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Record each accepted command transaction and check each delivered result transaction.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      shadow_list.delete();
      due_results.delete();
    end else begin
      if (in_valid && !in_stall) due_results.push_back(apply_command(cmd, value));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result with no command outstanding, expected none, got status %0d",
                   $time, status);
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_NOTFOUND) n_miss++;
          compare_field("status", want.status, status);
          compare_field("found", want.found, found);
          compare_field("entry_count", want.entry_count, entry_count);
          compare_field("head_value", want.head_value, head_value);
          compare_field("tail_value", want.tail_value, tail_value);
        end
      end
    end
    fail_count   <= errors;
    pending      <= due_results.size();
    checked      <= n_checked;
    full_rejects <= n_full;
    misses       <= n_miss;
  end

endmodule

// ----- tb/sv/tb_bounded_sorted_deque_core.sv -----
// Testbench top for the bounded sorted deque: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module tb_bounded_sorted_deque_core;
  import bsdq_pkg::*;

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_FROM   = 1100;
  localparam int DRAIN_CYCLES = 4 * CAPACITY + 20;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [CMD_W-1:0]         CMD_UNUSED = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MIN    = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX    = 32'sh7fff_ffff;

  // Command codes in the order of the weight tables below.
  localparam logic [CMD_W-1:0] CMD_ORDER[8] = '{CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT,
                                                CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE,
                                                CMD_SEARCH, CMD_UNUSED};

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} stim_mode_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         cmd = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      status;
  logic                     found;
  logic [COUNT_W-1:0]       entry_count;
  logic signed [DATA_W-1:0] head_value;
  logic signed [DATA_W-1:0] tail_value;

  int fail_count;
  int pending;
  int checked;
  int full_rejects;
  int misses;

  logic                     quiet = 1'b0;
  bit                       in_calm;
  bit                       out_calm;
  int                       stall_left;
  int                       cycle_count;
  int                       op_tally[8];
  logic signed [DATA_W-1:0] value_pool[8];

  bounded_sorted_deque_core #(.CAPACITY(CAPACITY)) u_dut (.*);

  bsdq_result_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result-side stall: random bursts, calm stretches, none near the end.
  always @(posedge clk) begin
    if (quiet || out_calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
    if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
  end

  // Values favor a small pool and a narrow range so that searches and deletes hit.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int                       roll;
    logic signed [DATA_W-1:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      v = value_pool[$urandom_range(0, 7)];
    end else if (roll < 70) begin
      v = int'($urandom_range(0, 16)) - 8;
    end else if (roll < 90) begin
      v = $urandom;
      value_pool[$urandom_range(0, 7)] = v;
    end else begin
      case ($urandom_range(0, 3))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = '0;
        default: v = -1;
      endcase
    end
    return v;
  endfunction

  // Weighted command choice; each table sums to 100.
  function automatic logic [CMD_W-1:0] pick_command(input stim_mode_t mode);
    int weight[8];
    int roll;
    int idx;
    case (mode)
      MODE_GROW:   weight = '{15, 15, 30, 8, 8, 10, 12, 2};
      MODE_SHRINK: weight = '{5, 5, 10, 22, 22, 22, 11, 3};
      default:     weight = '{10, 10, 20, 12, 12, 16, 17, 3};
    endcase
    roll = $urandom_range(0, 99);
    idx  = 0;
    while (roll >= weight[idx]) begin
      roll -= weight[idx];
      idx++;
    end
    return CMD_ORDER[idx];
  endfunction

  // Offer one command transaction, maybe after an idle burst, and wait for its acceptance.
  task automatic send_command(input logic [CMD_W-1:0] op, input logic signed [DATA_W-1:0] val);
    if (!quiet && !in_calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      cmd      <= CMD_W'($urandom);
      value    <= $urandom;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    value    <= val;
    do @(posedge clk); while (in_stall);
    op_tally[op]++;
  endtask

  initial begin
    int         sent;
    int         ep_len;
    int         mode_roll;
    stim_mode_t mode;

    for (int i = 0; i < 8; i++) value_pool[i] = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Commands on an empty list.
    send_command(CMD_POP_FRONT, VAL_MAX);
    send_command(CMD_POP_BACK, -1);
    send_command(CMD_DELETE, '0);
    send_command(CMD_SEARCH, '0);
    // Extreme values, ordering of equal values, hit and miss, spare code.
    send_command(CMD_PUSH_FRONT, VAL_MIN);
    send_command(CMD_PUSH_BACK, VAL_MAX);
    send_command(CMD_INSERT, '0);
    send_command(CMD_INSERT, VAL_MAX);
    send_command(CMD_INSERT, -1);
    send_command(CMD_SEARCH, VAL_MAX);
    send_command(CMD_SEARCH, 1);
    send_command(CMD_UNUSED, $urandom);
    // Fill the list, then try all three insert kinds on a full list.
    repeat (CAPACITY - 5) send_command(CMD_INSERT, int'($urandom_range(0, 40)) - 20);
    send_command(CMD_PUSH_FRONT, 7);
    send_command(CMD_PUSH_BACK, 7);
    send_command(CMD_INSERT, 7);
    send_command(CMD_DELETE, VAL_MIN);
    send_command(CMD_DELETE, 12345);

    // Random episodes that grow, drain or mix the list.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode_roll = $urandom_range(0, 9);
      mode      = (mode_roll < 4) ? MODE_GROW : (mode_roll < 7) ? MODE_SHRINK : MODE_MIX;
      in_calm   = ($urandom_range(0, 4) == 0);
      ep_len    = $urandom_range(8, 48);
      repeat (ep_len) begin
        if (sent == QUIET_FROM) quiet <= 1'b1;
        send_command(pick_command(mode), pick_value());
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Let every owed result arrive, then watch for stray ones.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands: %0d push front, %0d push back, %0d insert, %0d pop, %0d delete,",
             op_tally.sum(), op_tally[CMD_PUSH_FRONT], op_tally[CMD_PUSH_BACK],
             op_tally[CMD_INSERT], op_tally[CMD_POP_FRONT] + op_tally[CMD_POP_BACK],
             op_tally[CMD_DELETE]);
    $display("%0d search, %0d spare code; %0d results checked, %0d full rejects, %0d misses.",
             op_tally[CMD_SEARCH], op_tally[CMD_UNUSED], checked, full_rejects, misses);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bsdq_pkg.sv
rtl/core/bsdq_ram.sv
rtl/core/bsdq_out.sv
rtl/core/bounded_sorted_deque_core.sv
tb/sv/bsdq_result_checker.sv
tb/sv/tb_bounded_sorted_deque_core.sv
